// File: sv/sfm_pkg.sv
// Shared types for the substring first-match block: item opcodes,
// the queued item and the result record. No dependencies.
package sfm_pkg;

	typedef enum logic [1:0] {
		OP_CLEAR  = 2'd0,
		OP_APPEND = 2'd1,
		OP_TEXT   = 2'd2,
		OP_END    = 2'd3
	} op_t;

	typedef struct packed {
		op_t        op;
		logic [7:0] data;
	} item_t;

	typedef struct packed {
		logic        found;
		logic [31:0] match_index;
		logic        truncated;
	} result_t;

	localparam logic [31:0] POS_MAX = 32'hFFFF_FFFF;
	localparam int unsigned QUEUE_DEPTH = 2;

endpackage

// File: sv/sfm_front.sv
// Front side of the substring first-match block: accepts items, decodes
// the opcode and holds them in a two-entry queue for the back side.
// Depends on sfm_pkg.
module sfm_front (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  logic [1:0]    opcode,
	input  logic [7:0]    data_byte,
	output logic          full,
	output logic          item_valid,
	output sfm_pkg::item_t item,
	input  logic          item_take
);
	import sfm_pkg::*;

	item_t      mem_q [QUEUE_DEPTH];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] cnt_q;
	logic       do_wr;
	logic       do_rd;
	item_t      in_item;

	assign full       = (cnt_q == 2'(QUEUE_DEPTH));
	assign item_valid = (cnt_q != 2'd0);
	assign item       = mem_q[rd_ptr_q];
	assign do_wr      = push && !full;
	assign do_rd      = item_take && item_valid;

	always_comb begin
		in_item.op   = op_t'(opcode);
		in_item.data = data_byte;
	end

	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wr_ptr_q] <= in_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (do_rd) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			if (do_wr && !do_rd) begin
				cnt_q <= cnt_q + 2'd1;
			end else if (do_rd && !do_wr) begin
				cnt_q <= cnt_q - 2'd1;
			end
		end
	end

endmodule

// File: sv/sfm_back.sv
// Back side of the substring first-match block: pattern registers, the row
// of comparison cells, position and match latch, and the result queue.
// Depends on sfm_pkg.
module sfm_back #(
	parameter int unsigned MAX_PATTERN = 32
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           item_valid,
	input  sfm_pkg::item_t item,
	output logic           item_take,
	output logic           empty,
	input  logic           pop,
	output sfm_pkg::result_t result
);
	import sfm_pkg::*;

	localparam int unsigned LENW = $clog2(MAX_PATTERN + 1);
	localparam int unsigned IDXW = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;

	logic [7:0]             store_q [MAX_PATTERN];
	logic [LENW-1:0]        len_q;
	logic [MAX_PATTERN-1:0] part_q;
	logic [MAX_PATTERN-1:0] part_next;
	logic [MAX_PATTERN-1:0] last_mask;
	logic [31:0]            pos_q;
	logic [31:0]            first_q;
	logic                   seen_q;
	logic                   ovf_q;
	logic                   hit;
	logic                   len_zero;
	logic                   len_full;

	result_t    rq_q [QUEUE_DEPTH];
	logic       rq_wr_q;
	logic       rq_rd_q;
	logic [1:0] rq_cnt_q;
	logic       rq_full;
	logic       rq_push;
	logic       rq_pop;
	result_t    res_new;

	assign rq_full   = (rq_cnt_q == 2'(QUEUE_DEPTH));
	assign item_take = item_valid && (item.op != OP_END || !rq_full);
	assign len_zero  = (len_q == '0);
	assign len_full  = (len_q == LENW'(MAX_PATTERN));

	// each cell extends the match of its left neighbor by one byte
	always_comb begin
		for (int c = 0; c < MAX_PATTERN; c++) begin
			part_next[c] = ((c == 0) ? 1'b1 : part_q[(c == 0) ? 0 : c - 1])
				&& (store_q[c] == item.data) && (LENW'(c) < len_q);
			last_mask[c] = (LENW'(c + 1) == len_q);
		end
	end

	assign hit = |(part_next & last_mask);

	always_comb begin
		res_new.found       = len_zero ? 1'b1 : seen_q;
		res_new.match_index = (len_zero || !seen_q) ? 32'd0 : first_q;
		res_new.truncated   = ovf_q;
	end

	assign rq_push = item_take && item.op == OP_END;
	assign rq_pop  = pop && !empty;
	assign empty   = (rq_cnt_q == 2'd0);
	assign result  = rq_q[rq_rd_q];

	always_ff @(posedge clk) begin
		if (item_take && item.op == OP_APPEND && !len_full) begin
			store_q[len_q[IDXW-1:0]] <= item.data;
		end
		if (rq_push) begin
			rq_q[rq_wr_q] <= res_new;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q   <= '0;
			part_q  <= '0;
			pos_q   <= 32'd0;
			first_q <= 32'd0;
			seen_q  <= 1'b0;
			ovf_q   <= 1'b0;
		end else if (item_take) begin
			unique case (item.op)
				OP_CLEAR: begin
					len_q   <= '0;
					ovf_q   <= 1'b0;
					part_q  <= '0;
					pos_q   <= 32'd0;
					first_q <= 32'd0;
					seen_q  <= 1'b0;
				end
				OP_APPEND: begin
					if (len_full) begin
						ovf_q <= 1'b1;
					end else begin
						len_q <= len_q + LENW'(1);
					end
					part_q  <= '0;
					pos_q   <= 32'd0;
					first_q <= 32'd0;
					seen_q  <= 1'b0;
				end
				OP_TEXT: begin
					if (pos_q != POS_MAX) begin
						pos_q <= pos_q + 32'd1;
					end
					// hold the cells once the first match is latched
					if (!seen_q && !len_zero) begin
						part_q <= part_next;
						if (hit) begin
							seen_q  <= 1'b1;
							first_q <= pos_q - 32'(len_q) + 32'd1;
						end
					end
				end
				OP_END: begin
					part_q  <= '0;
					pos_q   <= 32'd0;
					first_q <= 32'd0;
					seen_q  <= 1'b0;
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rq_wr_q  <= 1'b0;
			rq_rd_q  <= 1'b0;
			rq_cnt_q <= 2'd0;
		end else begin
			if (rq_push) begin
				rq_wr_q <= ~rq_wr_q;
			end
			if (rq_pop) begin
				rq_rd_q <= ~rq_rd_q;
			end
			if (rq_push && !rq_pop) begin
				rq_cnt_q <= rq_cnt_q + 2'd1;
			end else if (rq_pop && !rq_push) begin
				rq_cnt_q <= rq_cnt_q - 2'd1;
			end
		end
	end

endmodule

// File: sv/substring_first_match_top.sv
// Substring first-match search: a pattern of up to MAX_PATTERN bytes is
// appended item by item, then text bytes stream in and a row of compare cells
// tracks every partial match at once; an end-of-text item yields one result
// (found, start index of the first occurrence, pattern truncated). The block
// takes one item per clock cycle unless a full queue stalls it: every item,
// text bytes included, is handled by the cell row as it is taken, and a
// two-entry queue on each side absorbs stalls. A result is registered in the
// result queue and shows on the result ports when nothing waits ahead of it.
// Depends on sfm_pkg, sfm_front and sfm_back.
module substring_first_match_top #(
	parameter int unsigned MAX_PATTERN = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	output logic        full,
	input  logic [1:0]  opcode,
	input  logic [7:0]  data_byte,
	output logic        empty,
	input  logic        pop,
	output logic        found,
	output logic [31:0] match_index,
	output logic        pattern_truncated
);
	import sfm_pkg::*;

	item_t   item;
	logic    item_valid;
	logic    item_take;
	result_t result;

	sfm_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.opcode     (opcode),
		.data_byte  (data_byte),
		.full       (full),
		.item_valid (item_valid),
		.item       (item),
		.item_take  (item_take)
	);

	sfm_back #(
		.MAX_PATTERN (MAX_PATTERN)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.item       (item),
		.item_take  (item_take),
		.empty      (empty),
		.pop        (pop),
		.result     (result)
	);

	assign found             = result.found;
	assign match_index       = result.match_index;
	assign pattern_truncated = result.truncated;

endmodule

// File: sv/sfm_checker.sv
// Port-level checks for substring_first_match_top, attached by bind.
// Depends only on the top level's ports.
module sfm_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        push,
	input logic        full,
	input logic        empty,
	input logic        pop,
	input logic        found,
	input logic [31:0] match_index,
	input logic        pattern_truncated
);

	// both queues come up empty while reset is held
	a_reset_state: assert property (@(posedge clk)
		!arst_n |-> (empty && !full))
		else $error("queues not empty in reset");

	// a missing match always reports index zero
	a_notfound_index: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !found) |-> (match_index == 32'd0))
		else $error("nonzero index on a miss");

	// the input side fills only through accepted items
	a_full_cause: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(full) |-> $past(push))
		else $error("full rose without a push");

	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !pop) |=> (!empty && $stable(found) && $stable(match_index)
			&& $stable(pattern_truncated)))
		else $error("waiting result changed");

endmodule

bind substring_first_match_top sfm_checker u_sfm_checker (.*);

// File: tb/sv/substring_first_match_top_tb.sv
// Self-checking testbench for substring_first_match_top: drives pattern,
// text and end-of-text items through the queue ports and checks each result.
// Depends on sfm_pkg and the substring_first_match_top RTL.
module substring_first_match_top_tb;
	import sfm_pkg::*;

	localparam int unsigned MAX_PAT         = 32;
	localparam int unsigned ITEMS_PER_PHASE = 680;
	localparam int unsigned CYCLE_LIMIT     = 400000;
	localparam int unsigned DRAIN_CYCLES    = 8;

	// Tracks pattern and search state, and queues the result expected for
	// each end-of-text item.
	class match_scoreboard #(int unsigned CAP = 32);
		logic [7:0]   pattern [CAP];
		int unsigned  pat_len;
		bit [CAP-1:0] partial;
		logic [31:0]  text_pos;
		bit           matched;
		logic [31:0]  first_idx;
		bit           truncated;
		result_t      expected_q [$];
		int unsigned  errors;

		function new();
			pat_len   = 0;
			truncated = 1'b0;
			errors    = 0;
			restart();
		endfunction

		function void restart();
			partial   = '0;
			text_pos  = '0;
			matched   = 1'b0;
			first_idx = '0;
		endfunction

		function void note_item(op_t op, logic [7:0] b);
			logic [31:0] pos;
			bit          prev;
			result_t     res;
			case (op)
			OP_CLEAR: begin
				pat_len   = 0;
				truncated = 1'b0;
				restart();
			end
			OP_APPEND: begin
				if (pat_len < CAP) begin
					pattern[pat_len] = b;
					pat_len++;
				end else begin
					truncated = 1'b1;
				end
				restart();
			end
			OP_TEXT: begin
				pos = text_pos;
				if (text_pos != POS_MAX)
					text_pos++;
				if (!matched && pat_len != 0) begin
					// advance every cell from the last one down
					for (int k = int'(pat_len) - 1; k >= 0; k--) begin
						prev = (k == 0) ? 1'b1 : partial[k-1];
						partial[k] = prev && (pattern[k] == b);
					end
					if (partial[pat_len-1]) begin
						matched   = 1'b1;
						first_idx = pos - 32'(pat_len - 1);
					end
				end
			end
			default: begin
				res.found       = (pat_len == 0) ? 1'b1 : matched;
				res.match_index = (pat_len == 0 || !matched) ? 32'd0 : first_idx;
				res.truncated   = truncated;
				expected_q.push_back(res);
				restart();
			end
			endcase
		endfunction

		function int unsigned outstanding();
			return expected_q.size();
		endfunction

		task report_mismatch(string msg);
			$display("ERROR @%0t: %s", $time, msg);
			errors++;
		endtask

		task check_result(logic f, logic [31:0] idx, logic tr);
			result_t want;
			if (expected_q.size() == 0) begin
				report_mismatch("result popped with no end-of-text item pending");
				return;
			end
			want = expected_q.pop_front();
			if (f !== want.found)
				report_mismatch($sformatf("found %b, want %b", f, want.found));
			if (idx !== want.match_index)
				report_mismatch($sformatf("match_index %0d, want %0d", idx,
					want.match_index));
			if (tr !== want.truncated)
				report_mismatch($sformatf("pattern_truncated %b, want %b", tr,
					want.truncated));
		endtask
	endclass

	logic        clk = 1'b0;
	logic        arst_n;
	logic        push;
	logic        full;
	op_t         opcode;
	logic [7:0]  data_byte;
	logic        empty;
	logic        pop;
	logic        found;
	logic [31:0] match_index;
	logic        pattern_truncated;

	match_scoreboard #(MAX_PAT) sb;
	int unsigned send_idle_pct;
	int unsigned recv_idle_pct;
	int unsigned items_sent;
	int unsigned cycles;
	bit          need_clear;
	logic [7:0]  cur_pat [$];

	substring_first_match_top #(.MAX_PATTERN(MAX_PAT)) dut (
		.clk               (clk),
		.arst_n            (arst_n),
		.push              (push),
		.full              (full),
		.opcode            (opcode),
		.data_byte         (data_byte),
		.empty             (empty),
		.pop               (pop),
		.found             (found),
		.match_index       (match_index),
		.pattern_truncated (pattern_truncated)
	);

	always #6 clk = ~clk;

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	// Result side: check on every accepted pop, then roll the next stall.
	always @(posedge clk) begin
		if (arst_n) begin
			if (pop && !empty)
				sb.check_result(found, match_index, pattern_truncated);
			pop <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	task automatic send_item(op_t op, logic [7:0] b);
		while ($urandom_range(99) < send_idle_pct) begin
			push <= 1'b0;
			@(posedge clk);
		end
		push      <= 1'b1;
		opcode    <= op;
		data_byte <= b;
		@(posedge clk);
		while (full)
			@(posedge clk);
		sb.note_item(op, b);
		items_sent++;
	endtask

	// One search: mostly clear, pattern, text, end, the text at times with a
	// planted copy; sometimes noise or an append in the middle of the text.
	task automatic run_sequence();
		logic [7:0]  alpha [2];
		logic [7:0]  txt [$];
		logic [7:0]  b;
		bit          full_range;
		int unsigned n;
		int unsigned plen;
		int unsigned at;
		int          split;
		if ($urandom_range(99) < 10) begin
			n = $urandom_range(1, 4);
			repeat (n)
				send_item(op_t'($urandom_range(3)), 8'($urandom));
			need_clear = 1'b1;
			return;
		end
		full_range = ($urandom_range(3) == 0);
		alpha[0]   = 8'($urandom);
		alpha[1]   = 8'($urandom);
		if (need_clear || $urandom_range(9) < 7) begin
			send_item(OP_CLEAR, 8'($urandom));
			cur_pat.delete();
			need_clear = 1'b0;
			plen = ($urandom_range(11) == 0) ? $urandom_range(MAX_PAT - 2, MAX_PAT + 3)
				: $urandom_range(0, 5);
			repeat (plen) begin
				b = full_range ? 8'($urandom) : alpha[$urandom_range(1)];
				send_item(OP_APPEND, b);
				if (cur_pat.size() < MAX_PAT)
					cur_pat.push_back(b);
			end
		end
		n = $urandom_range(0, cur_pat.size() + 16);
		repeat (n)
			txt.push_back(full_range ? 8'($urandom) : alpha[$urandom_range(1)]);
		if ($urandom_range(9) < 4 && cur_pat.size() <= n) begin
			at = $urandom_range(0, n - cur_pat.size());
			foreach (cur_pat[i])
				txt[at + i] = cur_pat[i];
		end
		split = ($urandom_range(9) == 0) ? int'($urandom_range(0, n)) : -1;
		for (int i = 0; i <= int'(n); i++) begin
			if (i == split) begin
				b = 8'($urandom);
				send_item(OP_APPEND, b);
				if (cur_pat.size() < MAX_PAT)
					cur_pat.push_back(b);
			end
			if (i < int'(n))
				send_item(OP_TEXT, txt[i]);
		end
		send_item(OP_END, 8'($urandom));
	endtask

	initial begin
		push      <= 1'b0;
		pop       <= 1'b0;
		opcode    <= OP_CLEAR;
		data_byte <= 8'h00;
		arst_n    <= 1'b0;
		sb = new();
		send_idle_pct = 16;
		recv_idle_pct = 79;
		items_sent    = 0;
		cycles        = 0;
		need_clear    = 1'b0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// empty pattern, empty text and then a nonempty text
		send_item(OP_END, 8'hFF);
		send_item(OP_TEXT, 8'h00);
		send_item(OP_TEXT, 8'hFF);
		send_item(OP_END, 8'h00);
		// text shorter than the pattern
		send_item(OP_APPEND, 8'hFF);
		send_item(OP_APPEND, 8'h00);
		send_item(OP_TEXT, 8'hFF);
		send_item(OP_END, 8'h55);
		// match at index 1, then a byte after the match
		send_item(OP_TEXT, 8'h00);
		send_item(OP_TEXT, 8'hFF);
		send_item(OP_TEXT, 8'h00);
		send_item(OP_TEXT, 8'hFF);
		send_item(OP_END, 8'hAA);
		// append in the middle of a text restarts the search
		send_item(OP_TEXT, 8'hFF);
		send_item(OP_APPEND, 8'h5A);
		send_item(OP_TEXT, 8'hFF);
		send_item(OP_TEXT, 8'h00);
		send_item(OP_TEXT, 8'h5A);
		send_item(OP_END, 8'h0F);
		send_item(OP_CLEAR, 8'hA5);
		send_item(OP_END, 8'hF0);

		for (int p = 0; p < 3; p++) begin
			send_idle_pct = (p == 0) ? 16 : (p == 1) ? 79 : 0;
			recv_idle_pct = (p == 0) ? 79 : (p == 1) ? 16 : 0;
			while (items_sent < (p + 1) * ITEMS_PER_PHASE)
				run_sequence();
			if (p == 0) begin
				// hold the sender until the result side has drained
				push <= 1'b0;
				@(posedge clk);
				while (sb.outstanding() != 0)
					@(posedge clk);
			end
		end

		push <= 1'b0;
		@(posedge clk);
		while (sb.outstanding() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (sb.errors == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule

// File: substring_first_match_top.f
sv/sfm_pkg.sv
sv/sfm_front.sv
sv/sfm_back.sv
sv/substring_first_match_top.sv
sv/sfm_checker.sv
tb/sv/substring_first_match_top_tb.sv
